[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers; they expect signals named clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/bsrwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrwc_pkg
// Shared constants, codes and control structs of the shadow write cache.
// ----------------------------------------------------------------------------
package bsrwc_pkg;

   localparam int NUM_CACHED_REGS = 127;
   localparam int NUM_BANKS       = 2;
   localparam int SHADOW_DEPTH    = NUM_CACHED_REGS * NUM_BANKS;
   localparam int SLOT_W          = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;

   localparam int ACT_W  = 2;
   localparam int REG_W  = 7;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 2 * BYTE_W;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;

   localparam logic [REG_W-1:0] BANK_SEL_REG = 7'h7F;

   // action codes
   localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_MASKED = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REPLY  = 2'd2;

   // bus operation codes
   localparam logic [OP_W-1:0] BUS_NONE  = 2'd0;
   localparam logic [OP_W-1:0] BUS_WRITE = 2'd1;
   localparam logic [OP_W-1:0] BUS_READ  = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_READ_FAIL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_PENDING = 2'd2;

   typedef struct packed {
      logic capture;   // latch request word, launch shadow read
      logic commit;    // resolve, write back, load result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_busy;  // result register full and not being taken
   } dp_status_type;

endpackage

[rtl/core/bsrwc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrwc_req_if
// Request channel: valid/ready plus one request word.
// ----------------------------------------------------------------------------
interface bsrwc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsrwc_pkg::ACT_W-1:0]   action;
   logic [bsrwc_pkg::REG_W-1:0]   register_index;
   logic [bsrwc_pkg::BYTE_W-1:0]  high_byte;
   logic [bsrwc_pkg::BYTE_W-1:0]  low_byte;
   logic [bsrwc_pkg::BYTE_W-1:0]  keep_mask_high;
   logic [bsrwc_pkg::BYTE_W-1:0]  keep_mask_low;
   logic                          bus_busy;
   logic                          reply_ok;
   logic [bsrwc_pkg::BYTE_W-1:0]  reply_high;
   logic [bsrwc_pkg::BYTE_W-1:0]  reply_low;

   modport source (
      output valid, action, register_index, high_byte, low_byte,
             keep_mask_high, keep_mask_low, bus_busy, reply_ok, reply_high, reply_low,
      input  ready
   );

   modport sink (
      input  valid, action, register_index, high_byte, low_byte,
             keep_mask_high, keep_mask_low, bus_busy, reply_ok, reply_high, reply_low,
      output ready
   );
endinterface

[rtl/core/bsrwc_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrwc_rsp_if
// Response channel: valid/ready plus one response word.
// ----------------------------------------------------------------------------
interface bsrwc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsrwc_pkg::OP_W-1:0]    bus_operation;
   logic [bsrwc_pkg::REG_W-1:0]   bus_register;
   logic [bsrwc_pkg::BYTE_W-1:0]  bus_high;
   logic [bsrwc_pkg::BYTE_W-1:0]  bus_low;
   logic                          write_suppressed;
   logic [bsrwc_pkg::STAT_W-1:0]  status;

   modport source (
      output valid, bus_operation, bus_register, bus_high, bus_low,
             write_suppressed, status,
      input  ready
   );

   modport sink (
      input  valid, bus_operation, bus_register, bus_high, bus_low,
             write_suppressed, status,
      output ready
   );
endinterface

[rtl/core/banked_shadow_register_write_cache_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_shadow_register_write_cache_unit
// Shadow write cache in front of a two-bank 16-bit register bus: drops
// writes that match the shadow, merges masked updates, tracks bank select.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           word
//  req_chan  in   valid/ready         action, register, bytes, masks, reply
//  rsp_chan  out  valid/ready         bus op, register, bytes, suppress, status
//
// Sequence: a word is resolved before the next is taken. The accept edge
//   launches the shadow RAM read; the resolve cycle compares or merges
//   against the read data, writes back and loads the response register.
// Reset: synchronous; valid bits, bank, pending read and response valid
//   clear. Shadow data has no reset and no clearing pass.
// Stalls: a new word is taken while a response still waits; the resolve
//   cycle holds while the response register is full and not being taken.
//
`include "assert_macros.svh"

module banked_shadow_register_write_cache_unit (
   input  logic        clock,
   input  logic        reset,
   bsrwc_req_if.sink   req_chan,
   bsrwc_rsp_if.source rsp_chan
);

   bsrwc_pkg::ctrl_cmd_type  cmd;
   bsrwc_pkg::dp_status_type stat;

   // sequencer: owns req ready and the capture / commit strobes
   bsrwc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // datapath: shadow store, bank and pending-read state, response register
   bsrwc_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .cmd     (cmd),
      .stat    (stat)
   );

   // capture and commit belong to different phases
   `ASSERT_ALWAYS(a_no_overlap, !(cmd.capture && cmd.commit), "capture and commit together")
   // after taking a word the block resolves it before taking another
   `ASSERT_NEXT(a_busy_after_take, cmd.capture, !req_chan.ready, "ready after capture")
   // every commit shows a response next cycle
   `ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_chan.valid, "commit without response")

endmodule

[rtl/core/bsrwc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrwc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsrwc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bsrwc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrwc_ctrl
// Two-state sequencer: take a request word, then resolve it.
// ----------------------------------------------------------------------------
module bsrwc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bsrwc_pkg::dp_status_type stat,
   output bsrwc_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_LOOK
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.capture = req_ready && req_valid;
   assign cmd.commit  = (state_ff == S_LOOK) && !stat.out_busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (cmd.commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/bsrwc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrwc_dp
// Datapath: request latch, shadow RAM and valid bits, bank and pending-read
// state, merge and compare logic, response register.
// ----------------------------------------------------------------------------
module bsrwc_dp (
   input  logic                     clock,
   input  logic                     reset,
   bsrwc_req_if.sink                req_chan,
   bsrwc_rsp_if.source              rsp_chan,
   input  bsrwc_pkg::ctrl_cmd_type  cmd,
   output bsrwc_pkg::dp_status_type stat
);

   localparam int SW = bsrwc_pkg::SLOT_W;
   localparam int BW = bsrwc_pkg::BYTE_W;
   localparam int RW = bsrwc_pkg::REG_W;

   // latched request word
   logic [bsrwc_pkg::ACT_W-1:0] act_ff;
   logic [RW-1:0]               reg_ff;
   logic [BW-1:0]               hi_ff, lo_ff, mh_ff, ml_ff, rh_ff, rl_ff;
   logic                        busy_ff, ok_ff;
   logic [SW-1:0]               slot_ff;

   // persistent state
   logic [bsrwc_pkg::SHADOW_DEPTH-1:0] valid_ff, valid_in;
   logic                               bank_ff, bank_in;
   logic                               pend_ff, pend_in;
   logic [RW-1:0]                      pend_reg_ff, pend_reg_in;
   logic [4*BW-1:0]                    pend_vm_ff, pend_vm_in;

   // response register
   logic                           out_valid_ff;
   logic [bsrwc_pkg::OP_W-1:0]     op_ff, op_in;
   logic [RW-1:0]                  breg_ff, breg_in;
   logic [BW-1:0]                  bhi_ff, bhi_in, blo_ff, blo_in;
   logic                           supp_ff, supp_in;
   logic [bsrwc_pkg::STAT_W-1:0]   st_ff, st_in;

   // shadow read address for the incoming word
   logic [RW-1:0]           rd_reg;
   logic [SW-1:0]           rd_slot;
   logic [bsrwc_pkg::WORD_W-1:0] old_word;

   assign rd_reg  = (req_chan.action == bsrwc_pkg::ACT_REPLY) ? pend_reg_ff
                                                               : req_chan.register_index;
   assign rd_slot = (bank_ff ? SW'(bsrwc_pkg::NUM_CACHED_REGS) : SW'(0)) + SW'(rd_reg);

   // resolve stage
   logic [RW-1:0]  eff_reg;
   logic           cached, hit;
   logic           pw_en;
   logic [RW-1:0]  pw_reg;
   logic [BW-1:0]  pw_hi, pw_lo;
   logic           ram_we;

   assign eff_reg = (act_ff == bsrwc_pkg::ACT_REPLY) ? pend_reg_ff : reg_ff;
   assign cached  = (eff_reg != bsrwc_pkg::BANK_SEL_REG) &&
                    ({1'b0, eff_reg} < (RW + 1)'(bsrwc_pkg::NUM_CACHED_REGS));
   assign hit     = cached && valid_ff[slot_ff];

   always_comb begin
      pw_en       = 1'b0;
      pw_reg      = reg_ff;
      pw_hi       = hi_ff;
      pw_lo       = lo_ff;
      pend_in     = pend_ff;
      pend_reg_in = pend_reg_ff;
      pend_vm_in  = pend_vm_ff;
      bank_in     = bank_ff;
      valid_in    = valid_ff;
      ram_we      = 1'b0;
      op_in       = bsrwc_pkg::BUS_NONE;
      breg_in     = '0;
      bhi_in      = '0;
      blo_in      = '0;
      supp_in     = 1'b0;
      st_in       = bsrwc_pkg::ST_OK;

      case (act_ff)
         bsrwc_pkg::ACT_WRITE: begin
            pw_en = 1'b1;
         end
         bsrwc_pkg::ACT_MASKED: begin
            if (hit) begin
               pw_en = 1'b1;
               pw_hi = hi_ff | (old_word[2*BW-1:BW] & mh_ff);
               pw_lo = lo_ff | (old_word[BW-1:0] & ml_ff);
            end else if (!busy_ff) begin
               pend_in     = 1'b1;
               pend_reg_in = reg_ff;
               pend_vm_in  = {hi_ff, lo_ff, mh_ff, ml_ff};
               op_in       = bsrwc_pkg::BUS_READ;
               breg_in     = reg_ff;
            end
         end
         bsrwc_pkg::ACT_REPLY: begin
            if (!pend_ff) begin
               st_in = bsrwc_pkg::ST_NO_PENDING;
            end else begin
               pend_in = 1'b0;
               if (!ok_ff) begin
                  st_in = bsrwc_pkg::ST_READ_FAIL;
               end else begin
                  pw_en  = 1'b1;
                  pw_reg = pend_reg_ff;
                  pw_hi  = pend_vm_ff[4*BW-1:3*BW] | (rh_ff & pend_vm_ff[2*BW-1:BW]);
                  pw_lo  = pend_vm_ff[3*BW-1:2*BW] | (rl_ff & pend_vm_ff[BW-1:0]);
               end
            end
         end
         default: begin
         end
      endcase

      // shared plain-write path
      if (pw_en) begin
         if (pw_reg == bsrwc_pkg::BANK_SEL_REG) begin
            bank_in = (bsrwc_pkg::NUM_BANKS > 1) ? pw_lo[0] : 1'b0;
         end else if (hit && (old_word == {pw_hi, pw_lo})) begin
            supp_in = 1'b1;
         end
         if (!supp_in && !busy_ff) begin
            op_in   = bsrwc_pkg::BUS_WRITE;
            breg_in = pw_reg;
            bhi_in  = pw_hi;
            blo_in  = pw_lo;
            if (cached) begin
               ram_we            = 1'b1;
               valid_in[slot_ff] = 1'b1;
            end
         end
      end
   end

   bsrwc_ram #(
      .WIDTH (bsrwc_pkg::WORD_W),
      .DEPTH (bsrwc_pkg::SHADOW_DEPTH),
      .ADDR_W(SW)
   ) u_shadow (
      .clock  (clock),
      .wr_en  (cmd.commit && ram_we),
      .wr_addr(slot_ff),
      .wr_data({pw_hi, pw_lo}),
      .rd_en  (cmd.capture),
      .rd_addr(rd_slot),
      .rd_data(old_word)
   );

   // request latch and response register, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_chan.action;
         reg_ff  <= req_chan.register_index;
         hi_ff   <= req_chan.high_byte;
         lo_ff   <= req_chan.low_byte;
         mh_ff   <= req_chan.keep_mask_high;
         ml_ff   <= req_chan.keep_mask_low;
         busy_ff <= req_chan.bus_busy;
         ok_ff   <= req_chan.reply_ok;
         rh_ff   <= req_chan.reply_high;
         rl_ff   <= req_chan.reply_low;
         slot_ff <= rd_slot;
      end
      if (cmd.commit) begin
         op_ff   <= op_in;
         breg_ff <= breg_in;
         bhi_ff  <= bhi_in;
         blo_ff  <= blo_in;
         supp_ff <= supp_in;
         st_ff   <= st_in;
      end
   end

   // control and cache state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         bank_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         pend_reg_ff  <= '0;
         pend_vm_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            valid_ff    <= valid_in;
            bank_ff     <= bank_in;
            pend_ff     <= pend_in;
            pend_reg_ff <= pend_reg_in;
            pend_vm_ff  <= pend_vm_in;
         end
         if (cmd.commit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_busy = out_valid_ff && !rsp_chan.ready;

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.bus_operation    = op_ff;
   assign rsp_chan.bus_register     = breg_ff;
   assign rsp_chan.bus_high         = bhi_ff;
   assign rsp_chan.bus_low          = blo_ff;
   assign rsp_chan.write_suppressed = supp_ff;
   assign rsp_chan.status           = st_ff;

endmodule
